[hw/rtl/m4inv_pkg.sv]
// m4inv_pkg: shared types, widths and state codes for the 4x4 matrix inverse
// used by the lanes, the divider and the top level; no dependencies
`default_nettype none
package m4inv_pkg;

   localparam int ELEM_W  = 32;
   localparam int ROW_W   = 4 * ELEM_W;
   localparam int COF_W   = 99;
   localparam int TERM_W  = 96;
   localparam int CMAG_W  = 128;
   localparam int DACC_W  = 130;
   localparam int DTERM_W = 131;
   localparam int DET_W   = 133;
   localparam int NTERMS  = 6;

   typedef struct packed {
      logic signed [ELEM_W-1:0] elem_0;
      logic signed [ELEM_W-1:0] elem_1;
      logic signed [ELEM_W-1:0] elem_2;
      logic signed [ELEM_W-1:0] elem_3;
      logic                     last_row;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] out_0;
      logic signed [ELEM_W-1:0] out_1;
      logic signed [ELEM_W-1:0] out_2;
      logic signed [ELEM_W-1:0] out_3;
      logic signed [ELEM_W-1:0] determinant;
      logic                     singular;
      logic                     saturated;
      logic                     last_out;
   } rsp_type;

   typedef struct packed {
      logic       start;
      logic       wr_en;
      logic [1:0] wr_row;
   } lane_ctrl_type;

   typedef struct packed {
      logic done;
   } lane_stat_type;

   typedef struct packed {
      logic done;
      logic sat;
   } div_stat_type;

   typedef enum logic [2:0] {
      ST_LOAD, ST_COF, ST_DET, ST_CHK, ST_SING, ST_DIV_GO, ST_DIV_WAIT, ST_OUT
   } top_state_type;

   typedef enum logic [3:0] {
      LN_IDLE, LN_RD0, LN_CAP0, LN_CAP1, LN_CAP2, LN_MLO, LN_MHI, LN_ACC, LN_FIN,
      LN_DRD, LN_DCAP, LN_DMUL, LN_DADD, LN_DFIN, LN_DONE
   } lane_state_type;

   typedef enum logic [2:0] {
      DV_IDLE, DV_PREP, DV_CHK, DV_ITER, DV_FIN, DV_DONE
   } div_state_type;

endpackage
`default_nettype wire

[hw/rtl/m4inv_ram.sv]
// m4inv_ram: generic single write port, single read port ram, registered read
// no dependencies
`default_nettype none
module m4inv_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[hw/rtl/m4inv_lane.sv]
// m4inv_lane: one cofactor lane, holds a copy of the matrix and computes the
// four cofactors of one column plus its determinant term; uses m4inv_pkg, m4inv_ram
`default_nettype none
module m4inv_lane (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic [1:0]                             lane_id,
   input  wire m4inv_pkg::lane_ctrl_type               ctrl,
   input  wire logic [m4inv_pkg::ROW_W-1:0]            wr_data,
   output m4inv_pkg::lane_stat_type                    stat,
   output logic [m4inv_pkg::ROW_W-1:0]                 rd_row,
   output logic signed [m4inv_pkg::COF_W-1:0]          cof [4],
   output logic signed [m4inv_pkg::DTERM_W-1:0]        dterm
);
   import m4inv_pkg::*;

   function automatic logic [1:0] skip_idx(input logic [1:0] i, input logic [1:0] ex);
      return (i < ex) ? i : i + 2'd1;
   endfunction

   function automatic logic [5:0] perm_cols(input logic [2:0] p);
      logic [5:0] c;
      unique case (p)
         3'd0:    c = {2'd2, 2'd1, 2'd0};
         3'd1:    c = {2'd0, 2'd2, 2'd1};
         3'd2:    c = {2'd1, 2'd0, 2'd2};
         3'd3:    c = {2'd1, 2'd2, 2'd0};
         3'd4:    c = {2'd0, 2'd1, 2'd2};
         3'd5:    c = {2'd2, 2'd0, 2'd1};
         default: c = {2'd2, 2'd1, 2'd0};
      endcase
      return c;
   endfunction

   lane_state_type state_ff, state_in;
   logic [1:0]   r_ff, k_ff;
   logic [2:0]   p_ff;
   logic [31:0]  mag0_ff, mag1_ff, mag2_ff, dmag_ff;
   logic         sgn0_ff, sgn1_ff, sgn2_ff, dsgn_ff;
   logic [63:0]  prod_ff, lo_ff, hi_ff, q_ff;
   logic signed [COF_W-1:0]   acc_ff;
   logic signed [COF_W-1:0]   cof_ff [4];
   logic [DACC_W-1:0]         dacc_ff;
   logic signed [DTERM_W-1:0] dterm_ff;

   logic [1:0]   rd_addr, cap_i, cap_col;
   logic [5:0]   cols;
   logic [31:0]  cap_elem, cap_mag, mul_a, mul_b;
   logic [63:0]  mul;
   logic [TERM_W-1:0] term_mag;
   logic signed [COF_W-1:0] term_ext;
   logic         term_neg;
   logic [COF_W-1:0]  cmag;
   logic [CMAG_W-1:0] cpad;
   logic [159:0]      q_sh;

   m4inv_ram #(.WIDTH(ROW_W), .DEPTH(4)) u_ram (
      .clock  (clock),
      .wr_en  (ctrl.wr_en),
      .wr_addr(ctrl.wr_row),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_row)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LN_IDLE, LN_DONE: begin
            if (ctrl.start) begin
               state_in = LN_RD0;
            end
         end
         LN_RD0:  state_in = LN_CAP0;
         LN_CAP0: state_in = LN_CAP1;
         LN_CAP1: state_in = LN_CAP2;
         LN_CAP2: state_in = LN_MLO;
         LN_MLO:  state_in = LN_MHI;
         LN_MHI:  state_in = LN_ACC;
         LN_ACC:  state_in = (p_ff == 3'(NTERMS - 1)) ? LN_FIN : LN_RD0;
         LN_FIN:  state_in = (r_ff == 2'd3) ? LN_DRD : LN_RD0;
         LN_DRD:  state_in = LN_DCAP;
         LN_DCAP: state_in = LN_DMUL;
         LN_DMUL: state_in = LN_DADD;
         LN_DADD: state_in = (k_ff == 2'd3) ? LN_DFIN : LN_DMUL;
         LN_DFIN: state_in = LN_DONE;
         default: state_in = LN_IDLE;
      endcase
   end

   always_comb begin
      rd_addr = lane_id;
      cap_i   = 2'd0;
      mul_a   = '0;
      mul_b   = '0;
      unique case (state_ff)
         LN_RD0:  rd_addr = skip_idx(2'd0, r_ff);
         LN_CAP0: rd_addr = skip_idx(2'd1, r_ff);
         LN_CAP1: begin
            rd_addr = skip_idx(2'd2, r_ff);
            cap_i   = 2'd1;
         end
         LN_CAP2: begin
            cap_i = 2'd2;
            mul_a = mag0_ff;
            mul_b = mag1_ff;
         end
         LN_MLO: begin
            mul_a = prod_ff[31:0];
            mul_b = mag2_ff;
         end
         LN_MHI: begin
            mul_a = prod_ff[63:32];
            mul_b = mag2_ff;
         end
         LN_DRD:  rd_addr = 2'd0;
         LN_DMUL: begin
            mul_a = cpad[32*k_ff +: 32];
            mul_b = dmag_ff;
         end
         default: rd_addr = lane_id;
      endcase
   end

   assign stat.done = (state_ff == LN_DONE);

   assign cols     = perm_cols(p_ff);
   assign cap_col  = skip_idx(cols[2*cap_i +: 2], lane_id);
   assign cap_elem = (state_ff == LN_DCAP) ? rd_row[32*lane_id +: 32]
                                           : rd_row[32*cap_col +: 32];
   assign cap_mag  = cap_elem[31] ? (32'd0 - cap_elem) : cap_elem;
   assign mul      = 64'(mul_a) * 64'(mul_b);
   assign term_mag = TERM_W'(lo_ff) + {hi_ff, 32'd0};
   assign term_ext = $signed({{(COF_W - TERM_W){1'b0}}, term_mag});
   assign term_neg = sgn0_ff ^ sgn1_ff ^ sgn2_ff ^ (p_ff >= 3'd3);
   assign cmag     = cof_ff[0][COF_W-1] ? COF_W'(-cof_ff[0]) : COF_W'(cof_ff[0]);
   assign cpad     = CMAG_W'(cmag);
   assign q_sh     = 160'(q_ff) << (32 * k_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LN_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         LN_IDLE, LN_DONE: begin
            r_ff   <= '0;
            p_ff   <= '0;
            acc_ff <= '0;
         end
         LN_CAP0: begin
            mag0_ff <= cap_mag;
            sgn0_ff <= cap_elem[31];
         end
         LN_CAP1: begin
            mag1_ff <= cap_mag;
            sgn1_ff <= cap_elem[31];
         end
         LN_CAP2: begin
            mag2_ff <= cap_mag;
            sgn2_ff <= cap_elem[31];
            prod_ff <= mul;
         end
         LN_MLO: lo_ff <= mul;
         LN_MHI: hi_ff <= mul;
         LN_ACC: begin
            acc_ff <= term_neg ? (acc_ff - term_ext) : (acc_ff + term_ext);
            p_ff   <= p_ff + 3'd1;
         end
         LN_FIN: begin
            cof_ff[r_ff] <= (r_ff[0] ^ lane_id[0]) ? -acc_ff : acc_ff;
            acc_ff       <= '0;
            p_ff         <= '0;
            r_ff         <= r_ff + 2'd1;
         end
         LN_DCAP: begin
            dmag_ff <= cap_mag;
            dsgn_ff <= cap_elem[31];
            dacc_ff <= '0;
            k_ff    <= '0;
         end
         LN_DMUL: q_ff <= mul;
         LN_DADD: begin
            dacc_ff <= dacc_ff + q_sh[DACC_W-1:0];
            k_ff    <= k_ff + 2'd1;
         end
         LN_DFIN: begin
            dterm_ff <= (dsgn_ff ^ cof_ff[0][COF_W-1]) ? -$signed({1'b0, dacc_ff})
                                                       : $signed({1'b0, dacc_ff});
         end
         default: begin
         end
      endcase
   end

   assign cof   = cof_ff;
   assign dterm = dterm_ff;

endmodule
`default_nettype wire

[hw/rtl/m4inv_div.sv]
// m4inv_div: shared restoring divider, signed quotient rounded half away from
// zero and saturated to 32 bits; uses m4inv_pkg
`default_nettype none
module m4inv_div #(
   parameter int NUM_W = 147
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [NUM_W-1:0]              num,
   input  wire logic signed [m4inv_pkg::DET_W-1:0]   den,
   output m4inv_pkg::div_stat_type                   stat,
   output logic [m4inv_pkg::ELEM_W-1:0]              quot
);
   import m4inv_pkg::*;

   localparam int N2_W = NUM_W + 1;
   localparam int D2_W = DET_W + 1;
   localparam int RW   = (N2_W > D2_W + 33) ? N2_W : D2_W + 33;

   div_state_type state_ff, state_in;
   logic signed [NUM_W-1:0] num_ff;
   logic signed [DET_W-1:0] den_ff;
   logic [N2_W-1:0] n2_ff;
   logic [D2_W-1:0] d2_ff;
   logic            neg_ff, big_ff, sat_ff;
   logic [RW-1:0]   rem_ff, dsh_ff;
   logic [32:0]     q_ff;
   logic [5:0]      cnt_ff;
   logic [31:0]     quot_ff;

   logic [NUM_W-1:0] nabs;
   logic [DET_W-1:0] dabs;
   logic [RW:0]      big_cmp;
   logic             ge, sat_now;
   logic [31:0]      lim, qv;

   assign nabs    = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign dabs    = den_ff[DET_W-1] ? DET_W'(-den_ff) : DET_W'(den_ff);
   assign big_cmp = (RW + 1)'(d2_ff) << 33;
   assign ge      = (rem_ff >= dsh_ff);
   assign lim     = neg_ff ? 32'h8000_0000 : 32'h7fff_ffff;
   assign sat_now = big_ff || (q_ff > 33'(lim));
   assign qv      = sat_now ? lim : q_ff[31:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DV_IDLE: begin
            if (start) begin
               state_in = DV_PREP;
            end
         end
         DV_PREP: state_in = DV_CHK;
         DV_CHK:  state_in = DV_ITER;
         DV_ITER: state_in = (cnt_ff == 6'd32) ? DV_FIN : DV_ITER;
         DV_FIN:  state_in = DV_DONE;
         DV_DONE: state_in = DV_IDLE;
         default: state_in = DV_IDLE;
      endcase
   end

   always_comb begin
      stat.done = (state_ff == DV_DONE);
      stat.sat  = sat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         DV_IDLE: begin
            num_ff <= num;
            den_ff <= den;
         end
         DV_PREP: begin
            n2_ff  <= {nabs, 1'b0} + N2_W'(dabs);
            d2_ff  <= {dabs, 1'b0};
            neg_ff <= num_ff[NUM_W-1] ^ den_ff[DET_W-1];
         end
         DV_CHK: begin
            big_ff <= ((RW + 1)'(n2_ff) >= big_cmp);
            rem_ff <= RW'(n2_ff);
            dsh_ff <= RW'(d2_ff) << 32;
            q_ff   <= '0;
            cnt_ff <= '0;
         end
         DV_ITER: begin
            if (ge) begin
               rem_ff <= rem_ff - dsh_ff;
            end
            q_ff   <= {q_ff[31:0], ge};
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff + 6'd1;
         end
         DV_FIN: begin
            quot_ff <= neg_ff ? (32'd0 - qv) : qv;
            sat_ff  <= sat_now;
         end
         default: begin
         end
      endcase
   end

   assign quot = quot_ff;

endmodule
`default_nettype wire

[hw/rtl/matrix4_inverse.sv]
// matrix4_inverse: 4x4 fixed point matrix inverse by cofactors, top level
// uses m4inv_pkg, m4inv_lane, m4inv_div
//
// Send the matrix as four row transfers, row 0 first, with last_row set on
// the fourth; four result rows follow, row 0 first, last_out on the fourth.
// Four cofactor lanes, one per column, each with one 32x32 multiplier, compute
// the cofactors and determinant terms. The determinant output is then rounded
// by a shift, and one shared divider produces the 16 inverse elements one after
// another. A singular matrix skips the divider and is echoed.
// New rows are taken only while no matrix is being computed or emitted.
`default_nettype none
module matrix4_inverse #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire m4inv_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output m4inv_pkg::rsp_type      rsp_data
);
   import m4inv_pkg::*;

   localparam int NUM_W = (DET_W > COF_W + 2 * FRAC_BITS) ? DET_W : COF_W + 2 * FRAC_BITS;
   localparam int DSH   = 3 * FRAC_BITS;
   localparam logic [DET_W:0] DET_HALF = (DET_W + 1)'(1) << (DSH - 1);

   top_state_type state_ff, state_in;
   logic [1:0]  row_cnt_ff, out_row_ff;
   logic [3:0]  idx_ff;
   logic signed [DET_W-1:0] det_ff;
   logic [ELEM_W-1:0] res_ff [16];
   logic [ELEM_W-1:0] det_out_ff;
   logic        sing_ff, sat_ff;

   lane_ctrl_type lane_ctrl;
   lane_stat_type lane_stat [4];
   logic [ROW_W-1:0] lane_row [4];
   logic signed [COF_W-1:0]   lane_cof [4][4];
   logic signed [DTERM_W-1:0] lane_dterm [4];
   logic        req_xfer, all_done, div_start;
   div_stat_type div_stat;
   logic [ELEM_W-1:0] div_quot;
   logic signed [NUM_W-1:0] div_num;
   logic signed [DET_W-1:0] div_den;

   logic [DET_W-1:0]  det_abs;
   logic [DET_W:0]    det_rnd;
   logic              det_neg, det_sat;
   logic [ELEM_W-1:0] det_lim, det_mag, det_q;

   for (genvar g = 0; g < 4; g++) begin : g_lane
      m4inv_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .lane_id(2'(g)),
         .ctrl   (lane_ctrl),
         .wr_data({req_data.elem_3, req_data.elem_2, req_data.elem_1, req_data.elem_0}),
         .stat   (lane_stat[g]),
         .rd_row (lane_row[g]),
         .cof    (lane_cof[g]),
         .dterm  (lane_dterm[g])
      );
   end

   m4inv_div #(.NUM_W(NUM_W)) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (div_num),
      .den  (div_den),
      .stat (div_stat),
      .quot (div_quot)
   );

   assign all_done = lane_stat[0].done & lane_stat[1].done & lane_stat[2].done
                   & lane_stat[3].done;
   assign div_num  = NUM_W'(lane_cof[idx_ff[3:2]][idx_ff[1:0]]) <<< (2 * FRAC_BITS);
   assign div_den  = det_ff;

   // determinant output, rounded half away from zero and saturated
   assign det_neg = det_ff[DET_W-1];
   assign det_abs = det_neg ? DET_W'(-det_ff) : DET_W'(det_ff);
   assign det_rnd = ((DET_W + 1)'(det_abs) + DET_HALF) >> DSH;
   assign det_lim = det_neg ? 32'h8000_0000 : 32'h7fff_ffff;
   assign det_sat = (det_rnd > (DET_W + 1)'(det_lim));
   assign det_mag = det_sat ? det_lim : det_rnd[ELEM_W-1:0];
   assign det_q   = det_neg ? (32'd0 - det_mag) : det_mag;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_xfer && req_data.last_row) begin
               state_in = ST_COF;
            end
         end
         ST_COF: begin
            if (all_done) begin
               state_in = ST_DET;
            end
         end
         ST_DET:  state_in = ST_CHK;
         ST_CHK:  state_in = (det_ff == '0) ? ST_SING : ST_DIV_GO;
         ST_SING: state_in = ST_OUT;
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = (idx_ff == 4'd15) ? ST_OUT : ST_DIV_GO;
            end
         end
         ST_OUT: begin
            if (rsp_ready && out_row_ff == 2'd3) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_ready        = (state_ff == ST_LOAD);
      rsp_valid        = (state_ff == ST_OUT);
      req_xfer         = req_valid && (state_ff == ST_LOAD);
      div_start        = (state_ff == ST_DIV_GO);
      lane_ctrl.wr_en  = req_xfer;
      lane_ctrl.wr_row = row_cnt_ff;
      lane_ctrl.start  = req_xfer && req_data.last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         row_cnt_ff <= '0;
         out_row_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (req_xfer) begin
            row_cnt_ff <= req_data.last_row ? 2'd0 : row_cnt_ff + 2'd1;
         end
         if (rsp_valid && rsp_ready) begin
            out_row_ff <= out_row_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_DET: begin
            det_ff <= DET_W'(lane_dterm[0]) + DET_W'(lane_dterm[1])
                    + DET_W'(lane_dterm[2]) + DET_W'(lane_dterm[3]);
         end
         ST_CHK: begin
            idx_ff     <= '0;
            sat_ff     <= det_sat;
            det_out_ff <= det_q;
            sing_ff    <= (det_ff == '0);
         end
         ST_SING: begin
            for (int l = 0; l < 4; l++) begin
               for (int e = 0; e < 4; e++) begin
                  res_ff[4*l+e] <= lane_row[l][32*e +: 32];
               end
            end
            det_out_ff <= '0;
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               res_ff[idx_ff] <= div_quot;
               sat_ff         <= sat_ff | div_stat.sat;
               idx_ff         <= idx_ff + 4'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data.out_0       = res_ff[{out_row_ff, 2'd0}];
      rsp_data.out_1       = res_ff[{out_row_ff, 2'd1}];
      rsp_data.out_2       = res_ff[{out_row_ff, 2'd2}];
      rsp_data.out_3       = res_ff[{out_row_ff, 2'd3}];
      rsp_data.determinant = det_out_ff;
      rsp_data.singular    = sing_ff;
      rsp_data.saturated   = sat_ff;
      rsp_data.last_out    = (out_row_ff == 2'd3);
   end

`ifndef SYNTHESIS
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      (lane_stat[0].done == lane_stat[1].done) && (lane_stat[0].done == lane_stat[2].done)
      && (lane_stat[0].done == lane_stat[3].done))
      else $error("cofactor lanes out of step");
   a_singular_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |-> rsp_data.determinant == '0 && !rsp_data.saturated)
      else $error("singular result carries determinant or saturation");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("row accepted while results pending");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_out |=> !rsp_valid && req_ready)
      else $error("result burst did not end after last row");
`endif

endmodule
`default_nettype wire
